// ===== design/fdes_pkg.sv =====
// ----------------------------------------------------------------------------
// fdes_pkg
// shared types, constants and helpers for the directory entry scanner
// ----------------------------------------------------------------------------
package fdes_pkg;

  // one directory byte
  typedef struct packed {
    logic [7:0] entry_byte;
    logic       new_scan;
  } fdes_in_t;

  // one result per 32-byte entry
  typedef struct packed {
    logic [1:0]  entry_status;
    logic [15:0] visible_index;
    logic [63:0] name_low;
    logic [31:0] name_high;
    logic [3:0]  name_length;
    logic [7:0]  attribute_bits;
    logic [31:0] cluster_start;
    logic [31:0] size_bytes;
  } fdes_out_t;

  // entry status codes
  localparam logic [1:0] STATUS_SKIP    = 2'd0;
  localparam logic [1:0] STATUS_VISIBLE = 2'd1;
  localparam logic [1:0] STATUS_MATCH   = 2'd2;

  // register indexes (address bits [5:3])
  localparam logic [2:0] REG_SEARCH_MODE   = 3'd0;
  localparam logic [2:0] REG_TARGET_LOW    = 3'd1;
  localparam logic [2:0] REG_TARGET_HIGH   = 3'd2;
  localparam logic [2:0] REG_TARGET_LENGTH = 3'd3;
  localparam logic [2:0] REG_TARGET_INDEX  = 3'd4;

  // search modes
  localparam logic MODE_NAME  = 1'b0;
  localparam logic MODE_INDEX = 1'b1;

  // byte markers
  localparam logic [7:0] FREE_MARK    = 8'h00;
  localparam logic [7:0] DELETED_MARK = 8'hE5;
  localparam logic [7:0] SKIP_ATTRS   = 8'h0E;
  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] DOT_CHAR     = 8'h2E;

  // byte positions inside an entry
  localparam logic [4:0] POS_FIRST     = 5'd0;
  localparam logic [4:0] POS_EXT_FIRST = 5'd8;
  localparam logic [4:0] POS_EXT_LAST  = 5'd10;
  localparam logic [4:0] POS_ATTR      = 5'd11;
  localparam logic [4:0] POS_CLHI_LO   = 5'd20;
  localparam logic [4:0] POS_CLHI_HI   = 5'd21;
  localparam logic [4:0] POS_CLLO_LO   = 5'd26;
  localparam logic [4:0] POS_CLLO_HI   = 5'd27;
  localparam logic [4:0] POS_SIZE_0    = 5'd28;
  localparam logic [4:0] POS_SIZE_1    = 5'd29;
  localparam logic [4:0] POS_SIZE_2    = 5'd30;
  localparam logic [4:0] POS_LAST      = 5'd31;

  localparam int          NAME_CHARS = 12;
  localparam logic [3:0]  NAME_MAX   = 4'd12;

  // lower ascii A..Z only
  function automatic logic [7:0] lower_ascii(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

// ===== design/fat_directory_entry_scanner_top.sv =====
// ----------------------------------------------------------------------------
// fat_directory_entry_scanner_top
// assembles fat32 directory entries from a byte stream and reports each one
// ----------------------------------------------------------------------------
// The block takes one directory byte per cycle whenever the input is not
// stalled: name compaction (space removal, lowering, dot insertion) is
// built up byte by byte as the name arrives, so the only wide logic at the
// end of an entry is the 12-character name compare and the output mux,
// both landing in the result register. A result appears in the cycle after
// the 32nd byte of an entry is accepted. The input side stalls only while
// a finished result sits in the result register and the consumer is not
// taking it. Registers are written through the apb-style port at byte
// address 8*i and should only be changed while no entry is in progress.
// ----------------------------------------------------------------------------
module fat_directory_entry_scanner_top #(
  parameter int INDEX_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst,
  // byte input
  input  logic                in_valid,
  output logic                in_ready,
  input  fdes_pkg::fdes_in_t  in_data,
  // result output
  output logic                out_valid,
  input  logic                out_ready,
  output fdes_pkg::fdes_out_t out_data,
  // register port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [5:0]          paddr,
  input  logic [63:0]         pwdata,
  output logic [63:0]         prdata,
  output logic                pready
);
  import fdes_pkg::*;

  // compare width covers both the counter and the 16-bit target index
  localparam int CMP_W = (INDEX_WIDTH > 16) ? INDEX_WIDTH : 16;

  // configuration registers
  logic        search_mode;
  logic [63:0] target_name_low;
  logic [31:0] target_name_high;
  logic [3:0]  target_name_length;
  logic [15:0] target_index;

  // entry assembly state
  logic [4:0]             byte_position;
  logic [INDEX_WIDTH-1:0] visible_count, visible_count_next;
  logic [7:0]             name_chars [NAME_CHARS];
  logic [7:0]             name_chars_next [NAME_CHARS];
  logic [3:0]             name_count, name_count_next;
  logic                   skip_mark, skip_mark_next;     // free or deleted
  logic                   ext_present, ext_present_next;
  logic [7:0]             attribute_store, attribute_store_next;
  logic [15:0]            cluster_high_store, cluster_high_store_next;
  logic [15:0]            cluster_low_store, cluster_low_store_next;
  logic [31:0]            size_store, size_store_next;

  logic       accept;
  logic [4:0] pos;
  logic [7:0] cur_byte;
  logic [7:0] cur_lower;
  logic       cur_space;
  logic       cfg_write;

  // ------------------------------------------------------------------
  // register port
  // ------------------------------------------------------------------
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      search_mode        <= MODE_NAME;
      target_name_low    <= '0;
      target_name_high   <= '0;
      target_name_length <= '0;
      target_index       <= '0;
    end else if (cfg_write) begin
      case (paddr[5:3])
        REG_SEARCH_MODE:   search_mode        <= pwdata[0];
        REG_TARGET_LOW:    target_name_low    <= pwdata;
        REG_TARGET_HIGH:   target_name_high   <= pwdata[31:0];
        REG_TARGET_LENGTH: target_name_length <= pwdata[3:0];
        REG_TARGET_INDEX:  target_index       <= pwdata[15:0];
        default: ;  // addresses past the last register are ignored
      endcase
    end
  end

  always_comb begin
    case (paddr[5:3])
      REG_SEARCH_MODE:   prdata = {63'd0, search_mode};
      REG_TARGET_LOW:    prdata = target_name_low;
      REG_TARGET_HIGH:   prdata = {32'd0, target_name_high};
      REG_TARGET_LENGTH: prdata = {60'd0, target_name_length};
      REG_TARGET_INDEX:  prdata = {48'd0, target_index};
      default:           prdata = '0;
    endcase
  end

  // ------------------------------------------------------------------
  // input handshake: stall only while an untaken result is held
  // ------------------------------------------------------------------
  assign in_ready  = !out_valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign cur_byte  = in_data.entry_byte;
  assign cur_lower = lower_ascii(cur_byte);
  assign cur_space = (cur_byte == SPACE_CHAR);
  // new_scan forces this byte to be byte 0 of an entry
  assign pos       = in_data.new_scan ? POS_FIRST : byte_position;

  // ------------------------------------------------------------------
  // per-byte assembly: name is compacted as it arrives
  // ------------------------------------------------------------------
  always_comb begin
    name_chars_next         = name_chars;
    name_count_next         = name_count;
    skip_mark_next          = skip_mark;
    ext_present_next        = ext_present;
    attribute_store_next    = attribute_store;
    cluster_high_store_next = cluster_high_store;
    cluster_low_store_next  = cluster_low_store;
    size_store_next         = size_store;

    if (pos == POS_FIRST) begin
      // fresh entry: clear name, first character goes to slot 0
      for (int k = 0; k < NAME_CHARS; k++) begin
        name_chars_next[k] = '0;
      end
      skip_mark_next  = (cur_byte == FREE_MARK) || (cur_byte == DELETED_MARK);
      name_count_next = '0;
      if (!cur_space) begin
        name_chars_next[0] = cur_lower;
        name_count_next    = 4'd1;
      end
    end else if (pos < POS_EXT_FIRST) begin
      if (!cur_space) begin
        name_chars_next[name_count] = cur_lower;
        name_count_next             = name_count + 4'd1;
      end
    end else if (pos == POS_EXT_FIRST) begin
      // extension present: dot then the first extension character
      ext_present_next = !cur_space;
      if (!cur_space) begin
        name_chars_next[name_count]        = DOT_CHAR;
        name_chars_next[name_count + 4'd1] = cur_lower;
        name_count_next                    = name_count + 4'd2;
      end
    end else if (pos <= POS_EXT_LAST) begin
      if (ext_present && !cur_space) begin
        name_chars_next[name_count] = cur_lower;
        name_count_next             = name_count + 4'd1;
      end
    end else if (pos == POS_ATTR) begin
      attribute_store_next = cur_byte;
    end else if (pos == POS_CLHI_LO) begin
      cluster_high_store_next[7:0] = cur_byte;
    end else if (pos == POS_CLHI_HI) begin
      cluster_high_store_next[15:8] = cur_byte;
    end else if (pos == POS_CLLO_LO) begin
      cluster_low_store_next[7:0] = cur_byte;
    end else if (pos == POS_CLLO_HI) begin
      cluster_low_store_next[15:8] = cur_byte;
    end else if (pos == POS_SIZE_0) begin
      size_store_next[7:0] = cur_byte;
    end else if (pos == POS_SIZE_1) begin
      size_store_next[15:8] = cur_byte;
    end else if (pos == POS_SIZE_2) begin
      size_store_next[23:16] = cur_byte;
    end else if (pos == POS_LAST) begin
      size_store_next[31:24] = cur_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= POS_FIRST;
      name_count    <= '0;
    end else if (accept) begin
      byte_position <= pos + 5'd1;  // wraps after the last byte
      name_count    <= name_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      name_chars         <= name_chars_next;
      skip_mark          <= skip_mark_next;
      ext_present        <= ext_present_next;
      attribute_store    <= attribute_store_next;
      cluster_high_store <= cluster_high_store_next;
      cluster_low_store  <= cluster_low_store_next;
      size_store         <= size_store_next;
    end
  end

  // ------------------------------------------------------------------
  // end of entry: classify, compare, count
  // ------------------------------------------------------------------
  logic                   entry_done;
  logic                   entry_skip;
  logic [INDEX_WIDTH-1:0] count_base;   // count after a possible new_scan clear
  logic [CMP_W-1:0]       count_ext;
  logic [7:0]             target_chars [NAME_CHARS];
  logic                   name_equal;
  logic                   index_equal;
  logic [1:0]             status;
  fdes_out_t              result;

  assign entry_done = accept && (pos == POS_LAST);
  assign entry_skip = skip_mark || ((attribute_store & SKIP_ATTRS) != 8'd0);
  assign count_base = in_data.new_scan ? '0 : visible_count;
  assign count_ext  = CMP_W'(count_base);

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      target_chars[k] = lower_ascii(target_name_low[8*k +: 8]);
    end
    for (int k = 0; k < 4; k++) begin
      target_chars[8 + k] = lower_ascii(target_name_high[8*k +: 8]);
    end
  end

  always_comb begin
    name_equal = (target_name_length == name_count);
    for (int k = 0; k < NAME_CHARS; k++) begin
      if ((4'(k) < name_count) && (target_chars[k] != name_chars[k])) begin
        name_equal = 1'b0;
      end
    end
  end

  assign index_equal = (count_ext == CMP_W'(target_index));

  always_comb begin
    if (entry_skip) begin
      status = STATUS_SKIP;
    end else if (search_mode == MODE_INDEX) begin
      status = index_equal ? STATUS_MATCH : STATUS_VISIBLE;
    end else begin
      status = name_equal ? STATUS_MATCH : STATUS_VISIBLE;
    end
  end

  // saturating visible count
  always_comb begin
    visible_count_next = count_base;
    if (entry_done && !entry_skip && (count_base != '1)) begin
      visible_count_next = count_base + INDEX_WIDTH'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      visible_count <= '0;
    end else if (accept) begin
      visible_count <= visible_count_next;
    end
  end

  always_comb begin
    result.entry_status  = status;
    result.visible_index = count_ext[15:0];
    for (int k = 0; k < 8; k++) begin
      result.name_low[8*k +: 8] = entry_skip ? 8'd0 : name_chars[k];
    end
    for (int k = 0; k < 4; k++) begin
      result.name_high[8*k +: 8] = entry_skip ? 8'd0 : name_chars[8 + k];
    end
    result.name_length    = entry_skip ? 4'd0 : name_count;
    result.attribute_bits = attribute_store;
    result.cluster_start  = {cluster_high_store, cluster_low_store};
    result.size_bytes     = size_store_next;
  end

  // ------------------------------------------------------------------
  // result register
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (entry_done) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (entry_done) begin
      out_data <= result;
    end
  end

  // ------------------------------------------------------------------
  // checks
  // ------------------------------------------------------------------
  // the last byte of an entry always produces a result next cycle
  a_result_follows_last: assert property (@(posedge clk) disable iff (rst)
    entry_done |=> out_valid)
    else $error("no result after last entry byte");

  // compacted name never exceeds twelve characters
  a_name_bound: assert property (@(posedge clk) disable iff (rst)
    name_count <= NAME_MAX)
    else $error("name character count out of range");

  // skipped entries carry an empty name
  a_skip_empty_name: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.entry_status == STATUS_SKIP) |->
      (out_data.name_length == 4'd0 && out_data.name_low == 64'd0 &&
       out_data.name_high == 32'd0))
    else $error("skipped entry with a name");

  // visible count moves only on a visible entry or a new scan
  a_count_moves: assert property (@(posedge clk) disable iff (rst)
    (!accept || (!entry_done && !in_data.new_scan)) |=> $stable(visible_count))
    else $error("visible count changed outside an entry end");

endmodule
